// ----- rtl/core/rtd_code_to_fahrenheit_top_macros.svh -----
// ----------------------------------------------------------------------------
// rtd_code_to_fahrenheit_top_macros.svh
// assertion helpers for the rtd converter, expects clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef RTD_CODE_TO_FAHRENHEIT_TOP_MACROS_SVH
`define RTD_CODE_TO_FAHRENHEIT_TOP_MACROS_SVH

// same-cycle implication
`define RTDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtdf check failed");

// implication after a fixed number of cycles
`define RTDF_ASSERT_LATER(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("rtdf delayed check failed");

`endif

// ----- rtl/core/rtdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdf_pkg
// shared types and constants of the rtd code to fahrenheit converter
// ----------------------------------------------------------------------------
package rtdf_pkg;

  localparam int TEMP_FRAC_BITS = 4;
  localparam int SCALE          = 2 ** TEMP_FRAC_BITS;

  // config register widths and indexes
  localparam int REF_W = 14;
  localparam int NOM_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EN  = 2'd2;

  // resistance ratio stage: xs = floor(floor(code * ref * 9765625 / 32) / r0)
  localparam int CODE_W   = 15;
  localparam int M_W      = CODE_W + REF_W;
  localparam int P_W      = M_W + 24;
  localparam int XS_W     = P_W - 5;
  localparam int XS_STEPS = XS_W;
  localparam logic [23:0] XS_MUL = 24'd9765625;

  // discriminant: d18 = (a^2 - 4b) * 1e18 - 231 * xs
  localparam int RAD_W      = 44;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int DIFF_W     = 38;
  localparam logic [63:0] ONE_E10 = 64'd10000000000;
  localparam logic [63:0] DISC_K  = 64'd17584808890000;
  localparam logic [7:0]  FOUR_B  = 8'd231;

  // denominator and final rounded quotient
  localparam int DEN_W   = ROOT_W + 1;
  localparam logic [63:0] A_E9 = 64'd3908300;
  localparam int D_W     = 29;
  localparam int Q_STEPS = 14 + TEMP_FRAC_BITS;
  localparam int N_W     = D_W + Q_STEPS;
  localparam int NS_W    = N_W + 1;
  localparam int Q_OFFSET = 512 * SCALE;
  localparam int MUL_DIFF = 18 * SCALE;
  localparam int MUL_DEN  = 25 + 1600 * SCALE + 50 * Q_OFFSET;
  localparam int VAL_W   = Q_STEPS + 2;

  localparam int TEMP_W = 16;

  localparam int LATENCY = 3 + XS_STEPS + 1 + SQRT_STEPS + 2 + Q_STEPS + 1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_EN     = 3'd1,
    ST_DEV_FAULT  = 3'd2,
    ST_CODE_FAULT = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  // side data riding along with each word
  typedef struct packed {
    logic       valid;
    logic       force_v;
    logic       force_hi;
    status_t    status;
    logic [7:0] fault_bits;
  } meta_t;

endpackage

// ----- rtl/core/rtdf_xs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdf_xs_cell
// one restoring division step of the resistance ratio by the nominal ohms
// ----------------------------------------------------------------------------
module rtdf_xs_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rtdf_pkg::NOM_W-1:0]   divisor_i,
  input  rtdf_pkg::meta_t              meta_i,
  input  logic [rtdf_pkg::NOM_W-1:0]   rem_i,
  input  logic [rtdf_pkg::XS_W-1:0]    nq_i,
  output rtdf_pkg::meta_t              meta_o,
  output logic [rtdf_pkg::NOM_W-1:0]   rem_o,
  output logic [rtdf_pkg::XS_W-1:0]    nq_o
);
  import rtdf_pkg::*;

  logic [NOM_W:0]   trial;
  logic [NOM_W:0]   sub;
  logic             ge;
  logic [NOM_W-1:0] rem_nxt;
  logic [XS_W-1:0]  nq_nxt;
  meta_t            meta_r;
  logic [NOM_W-1:0] rem_r;
  logic [XS_W-1:0]  nq_r;

  always_comb begin
    trial   = {rem_i, nq_i[XS_W-1]};
    sub     = trial - {1'b0, divisor_i};
    ge      = trial >= {1'b0, divisor_i};
    rem_nxt = ge ? sub[NOM_W-1:0] : trial[NOM_W-1:0];
    // numerator bits leave at the top, quotient bits enter at the bottom
    nq_nxt  = {nq_i[XS_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
  end

  assign meta_o = meta_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;

endmodule

// ----- rtl/core/rtdf_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdf_sqrt_cell
// one digit step of the restoring integer square root of the discriminant
// ----------------------------------------------------------------------------
module rtdf_sqrt_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rtdf_pkg::meta_t                   meta_i,
  input  logic [rtdf_pkg::RAD_W-1:0]        rad_i,
  input  logic [rtdf_pkg::SREM_W-1:0]       rem_i,
  input  logic [rtdf_pkg::ROOT_W-1:0]       root_i,
  input  logic signed [rtdf_pkg::DIFF_W-1:0] diff_i,
  output rtdf_pkg::meta_t                   meta_o,
  output logic [rtdf_pkg::RAD_W-1:0]        rad_o,
  output logic [rtdf_pkg::SREM_W-1:0]       rem_o,
  output logic [rtdf_pkg::ROOT_W-1:0]       root_o,
  output logic signed [rtdf_pkg::DIFF_W-1:0] diff_o
);
  import rtdf_pkg::*;

  logic [SREM_W+1:0]        cur;
  logic [SREM_W+1:0]        trial;
  logic [SREM_W+1:0]        sub;
  logic                     ge;
  logic [SREM_W-1:0]        rem_nxt;
  logic [ROOT_W-1:0]        root_nxt;
  logic [RAD_W-1:0]         rad_nxt;
  meta_t                    meta_r;
  logic [RAD_W-1:0]         rad_r;
  logic [SREM_W-1:0]        rem_r;
  logic [ROOT_W-1:0]        root_r;
  logic signed [DIFF_W-1:0] diff_r;

  always_comb begin
    cur      = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial    = (SREM_W + 2)'({root_i, 2'b01});
    sub      = cur - trial;
    ge       = cur >= trial;
    rem_nxt  = ge ? sub[SREM_W-1:0] : cur[SREM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    diff_r <= diff_i;
  end

  assign meta_o = meta_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign diff_o = diff_r;

endmodule

// ----- rtl/core/rtdf_quo_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdf_quo_cell
// one restoring division step of the rounded fahrenheit quotient
// ----------------------------------------------------------------------------
module rtdf_quo_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rtdf_pkg::meta_t                meta_i,
  input  logic [rtdf_pkg::D_W-1:0]       d_i,
  input  logic [rtdf_pkg::D_W-1:0]       rem_i,
  input  logic [rtdf_pkg::Q_STEPS-1:0]   nq_i,
  output rtdf_pkg::meta_t                meta_o,
  output logic [rtdf_pkg::D_W-1:0]       d_o,
  output logic [rtdf_pkg::D_W-1:0]       rem_o,
  output logic [rtdf_pkg::Q_STEPS-1:0]   nq_o
);
  import rtdf_pkg::*;

  logic [D_W:0]       trial;
  logic [D_W:0]       sub;
  logic               ge;
  logic [D_W-1:0]     rem_nxt;
  logic [Q_STEPS-1:0] nq_nxt;
  meta_t              meta_r;
  logic [D_W-1:0]     d_r;
  logic [D_W-1:0]     rem_r;
  logic [Q_STEPS-1:0] nq_r;

  always_comb begin
    trial   = {rem_i, nq_i[Q_STEPS-1]};
    sub     = trial - {1'b0, d_i};
    ge      = trial >= {1'b0, d_i};
    rem_nxt = ge ? sub[D_W-1:0] : trial[D_W-1:0];
    nq_nxt  = {nq_i[Q_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_i;
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
  end

  assign meta_o = meta_r;
  assign d_o    = d_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;

endmodule

// ----- rtl/core/rtd_code_to_fahrenheit_top.sv -----
`timescale 1ns / 1ps
// path: s0-s2, ratio cells, s3, root cells, s4, s5, quotient cells, output reg
// throughput: one reading per cycle, set by fully pipelined cell chains
//   (48 ratio divider cells, 22 square root cells, 18 quotient cells)
// reset: synchronous, clears the valid pipeline and restores register defaults;
//   busy is high only while reset is held, the result side never stalls
// ----------------------------------------------------------------------------
// rtd_code_to_fahrenheit_top
// rtd converter code to fahrenheit x16 through the inverse cvd quadratic
// ----------------------------------------------------------------------------
`include "rtd_code_to_fahrenheit_top_macros.svh"

module rtd_code_to_fahrenheit_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [7:0]                         in_fault_status,
  input  logic [7:0]                         in_rtd_high_byte,
  input  logic [7:0]                         in_rtd_low_byte,
  output logic                               out_valid,
  output logic signed [rtdf_pkg::TEMP_W-1:0] out_temp_f_x16,
  output logic [2:0]                         out_status,
  output logic [7:0]                         out_fault_bits,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtdf_pkg::REF_W-1:0]         cfg_data
);
  import rtdf_pkg::*;

  localparam logic signed [NS_W-1:0]  MUL_DIFF_S = NS_W'(MUL_DIFF);
  localparam logic [NS_W-1:0]         MUL_DEN_U  = NS_W'(MUL_DEN);
  localparam logic signed [VAL_W-1:0] VAL_MAX    = VAL_W'(32767);
  localparam logic signed [VAL_W-1:0] VAL_MIN    = VAL_W'(-32768);
  localparam logic signed [VAL_W-1:0] VAL_OFF    = VAL_W'(Q_OFFSET);
  localparam logic signed [TEMP_W-1:0] TEMP_HI   = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_LO   = -16'sh8000;

  // configuration
  logic [REF_W-1:0] ref_r;
  logic [NOM_W-1:0] nom_r;
  logic             en_r;

  logic             accept;
  meta_t            meta_in;

  meta_t            s0_meta_r;
  logic [CODE_W-1:0] s0_code_r;
  meta_t            s1_meta_r;
  logic [M_W-1:0]   s1_m_r;
  meta_t            s2_meta_r;
  logic [XS_W-1:0]  s2_q1_r;
  logic [P_W-1:0]   p_prod;

  meta_t            xs_meta [0:XS_STEPS];
  logic [NOM_W-1:0] xs_rem  [0:XS_STEPS];
  logic [XS_W-1:0]  xs_nq   [0:XS_STEPS];

  logic [XS_W+7:0]  disc_prod;
  logic             disc_neg;
  logic [XS_W:0]    diff_full;
  meta_t            s3_meta_nxt;
  meta_t            s3_meta_r;
  logic [RAD_W-1:0] s3_d18_r;
  logic signed [DIFF_W-1:0] s3_diff_r;

  meta_t                    sq_meta [0:SQRT_STEPS];
  logic [RAD_W-1:0]         sq_rad  [0:SQRT_STEPS];
  logic [SREM_W-1:0]        sq_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0]        sq_root [0:SQRT_STEPS];
  logic signed [DIFF_W-1:0] sq_diff [0:SQRT_STEPS];

  meta_t                    s4_meta_r;
  logic [DEN_W-1:0]         s4_den_r;
  logic signed [DIFF_W-1:0] s4_diff_r;

  logic signed [NS_W-1:0]   diff_ext;
  logic signed [NS_W-1:0]   diff_term;
  logic [NS_W-1:0]          den_term;
  logic signed [NS_W-1:0]   n_sum;
  meta_t                    s5_meta_r;
  logic [N_W-1:0]           s5_n_r;
  logic [D_W-1:0]           s5_d_r;

  meta_t              qu_meta [0:Q_STEPS];
  logic [D_W-1:0]     qu_d    [0:Q_STEPS];
  logic [D_W-1:0]     qu_rem  [0:Q_STEPS];
  logic [Q_STEPS-1:0] qu_nq   [0:Q_STEPS];

  meta_t                    fin_meta;
  logic signed [VAL_W-1:0]  val;
  logic signed [TEMP_W-1:0] temp_nxt;
  status_t                  status_nxt;
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  status_t                  out_status_r;
  logic [7:0]               out_fault_r;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_W'(430);
      nom_r <= NOM_W'(100);
      en_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REF: ref_r <= cfg_data;
        CFG_NOM: nom_r <= cfg_data[NOM_W-1:0];
        CFG_EN:  en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // early exits decided at entry, in priority order
  always_comb begin
    meta_in            = '0;
    meta_in.valid      = accept;
    meta_in.fault_bits = in_fault_status;
    meta_in.force_hi   = 1'b0;
    meta_in.force_v    = 1'b1;
    if (!en_r) begin
      meta_in.status = ST_NOT_EN;
    end else if (in_fault_status != 8'd0) begin
      meta_in.status = ST_DEV_FAULT;
    end else if (in_rtd_low_byte[0]) begin
      meta_in.status = ST_CODE_FAULT;
    end else if (nom_r == '0) begin
      meta_in.status = ST_RANGE;
    end else begin
      meta_in.status  = ST_OK;
      meta_in.force_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_meta_r.valid <= 1'b0;
      s1_meta_r.valid <= 1'b0;
      s2_meta_r.valid <= 1'b0;
      s3_meta_r.valid <= 1'b0;
      s4_meta_r.valid <= 1'b0;
      s5_meta_r.valid <= 1'b0;
    end else begin
      s0_meta_r <= meta_in;
      s1_meta_r <= s0_meta_r;
      s2_meta_r <= s1_meta_r;
      s3_meta_r <= s3_meta_nxt;
      s4_meta_r <= sq_meta[SQRT_STEPS];
      s5_meta_r <= s4_meta_r;
    end
  end

  assign p_prod = P_W'(s1_m_r) * P_W'(XS_MUL);

  always_ff @(posedge clk) begin
    s0_code_r <= {in_rtd_high_byte, in_rtd_low_byte[7:1]};
    s1_m_r    <= M_W'(s0_code_r) * M_W'(ref_r);
    s2_q1_r   <= p_prod[P_W-1:5];
  end

  // ratio divider chain; divisor held steady only if the user changes config when idle, unenforced by the block
  assign xs_meta[0] = s2_meta_r;
  assign xs_rem[0]  = '0;
  assign xs_nq[0]   = s2_q1_r;

  for (genvar g = 0; g < XS_STEPS; g++) begin : g_xs
    rtdf_xs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor_i (nom_r),
      .meta_i    (xs_meta[g]),
      .rem_i     (xs_rem[g]),
      .nq_i      (xs_nq[g]),
      .meta_o    (xs_meta[g+1]),
      .rem_o     (xs_rem[g+1]),
      .nq_o      (xs_nq[g+1])
    );
  end

  // discriminant, negative one saturates high
  always_comb begin
    disc_prod   = (XS_W + 8)'(xs_nq[XS_STEPS]) * (XS_W + 8)'(FOUR_B);
    disc_neg    = disc_prod > (XS_W + 8)'(DISC_K);
    diff_full   = (XS_W + 1)'(xs_nq[XS_STEPS]) - (XS_W + 1)'(ONE_E10);
    s3_meta_nxt = xs_meta[XS_STEPS];
    if (!s3_meta_nxt.force_v && disc_neg) begin
      s3_meta_nxt.force_v  = 1'b1;
      s3_meta_nxt.force_hi = 1'b1;
      s3_meta_nxt.status   = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    s3_d18_r  <= RAD_W'(DISC_K) - disc_prod[RAD_W-1:0];
    s3_diff_r <= $signed(diff_full[DIFF_W-1:0]);
  end

  assign sq_meta[0] = s3_meta_r;
  assign sq_rad[0]  = s3_d18_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_diff[0] = s3_diff_r;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    rtdf_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .meta_i (sq_meta[g]),
      .rad_i  (sq_rad[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .diff_i (sq_diff[g]),
      .meta_o (sq_meta[g+1]),
      .rad_o  (sq_rad[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .diff_o (sq_diff[g+1])
    );
  end

  always_ff @(posedge clk) begin
    s4_den_r  <= DEN_W'(sq_root[SQRT_STEPS]) + DEN_W'(A_E9);
    s4_diff_r <= sq_diff[SQRT_STEPS];
  end

  // numerator carries the half-up rounding and an offset that keeps it positive
  always_comb begin
    diff_ext  = NS_W'(s4_diff_r);
    diff_term = diff_ext * MUL_DIFF_S;
    den_term  = NS_W'(s4_den_r) * MUL_DEN_U;
    n_sum     = diff_term + $signed(den_term);
  end

  always_ff @(posedge clk) begin
    s5_n_r <= n_sum[N_W-1:0];
    s5_d_r <= D_W'(s4_den_r) * D_W'(50);
  end

  assign qu_meta[0] = s5_meta_r;
  assign qu_d[0]    = s5_d_r;
  assign qu_rem[0]  = s5_n_r[N_W-1:Q_STEPS];
  assign qu_nq[0]   = s5_n_r[Q_STEPS-1:0];

  for (genvar g = 0; g < Q_STEPS; g++) begin : g_quo
    rtdf_quo_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .meta_i (qu_meta[g]),
      .d_i    (qu_d[g]),
      .rem_i  (qu_rem[g]),
      .nq_i   (qu_nq[g]),
      .meta_o (qu_meta[g+1]),
      .d_o    (qu_d[g+1]),
      .rem_o  (qu_rem[g+1]),
      .nq_o   (qu_nq[g+1])
    );
  end

  always_comb begin
    fin_meta   = qu_meta[Q_STEPS];
    val        = $signed({2'b00, qu_nq[Q_STEPS]}) - VAL_OFF;
    status_nxt = fin_meta.status;
    if (fin_meta.force_v) begin
      temp_nxt = fin_meta.force_hi ? TEMP_HI : '0;
    end else if (val > VAL_MAX) begin
      temp_nxt   = TEMP_HI;
      status_nxt = ST_RANGE;
    end else if (val < VAL_MIN) begin
      temp_nxt   = TEMP_LO;
      status_nxt = ST_RANGE;
    end else begin
      temp_nxt = val[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_temp_r   <= temp_nxt;
    out_status_r <= status_nxt;
    out_fault_r  <= fin_meta.fault_bits;
  end

  assign out_valid      = out_valid_r;
  assign out_temp_f_x16 = out_temp_r;
  assign out_status     = out_status_r;
  assign out_fault_bits = out_fault_r;

  `RTDF_ASSERT_LATER(a_latency, accept, LATENCY, out_valid)
  `RTDF_ASSERT_LATER(a_not_en, accept && !en_r, LATENCY, out_status == ST_NOT_EN)
  `RTDF_ASSERT_NOW(a_fault_zero, out_valid && (out_status == ST_NOT_EN || out_status == ST_DEV_FAULT || out_status == ST_CODE_FAULT), out_temp_f_x16 == '0)
  `RTDF_ASSERT_NOW(a_ok_no_fault, out_valid && out_status == ST_OK, out_fault_bits == 8'd0)

endmodule
